// ----- hw/rtl/bvat_pkg.sv -----
package bvat_pkg;

    localparam int STEPS = 28;
    localparam int CW = 34;
    localparam int MW = 35;
    localparam int PW = 67;
    localparam int SW = 69;
    localparam int RW = SW - 31;
    localparam logic [2:0] LAST_CORNER = 3'd7;

    localparam logic signed [CW-1:0] GAIN_INV = 34'sd652032874;
    localparam logic signed [35:0] PI_Q30 = 36'sd3373259426;
    localparam logic signed [35:0] HALF_PI_Q30 = 36'sd1686629713;

    localparam logic signed [CW-1:0] ATAN_Q30 [STEPS] = '{
        34'sd843314856, 34'sd497837829, 34'sd263043836, 34'sd133525158,
        34'sd67021686, 34'sd33543515, 34'sd16775850, 34'sd8388437,
        34'sd4194282, 34'sd2097149, 34'sd1048575, 34'sd524287,
        34'sd262143, 34'sd131071, 34'sd65535, 34'sd32767,
        34'sd16383, 34'sd8191, 34'sd4095, 34'sd2047,
        34'sd1023, 34'sd511, 34'sd255, 34'sd127,
        34'sd63, 34'sd31, 34'sd15, 34'sd7
    };

    typedef struct packed {
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [31:0] size_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [31:0] shift_z;
        logic signed [15:0] angle_x;
        logic signed [15:0] angle_y;
        logic signed [15:0] angle_z;
    } bvat_in_t;

    typedef struct packed {
        logic [2:0]         corner_index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               last_corner;
    } bvat_out_t;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
    } cord_t;

    typedef struct packed {
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic signed [31:0] size_z;
        logic signed [31:0] shift_x;
        logic signed [31:0] shift_y;
        logic signed [32:0] shift_nz;
    } box_t;

    function automatic cord_t cordic_step(cord_t s, int k);
        cord_t r;
        if (s.z >= 0)
        begin
            r.x = s.x - (s.y >>> k);
            r.y = s.y + (s.x >>> k);
            r.z = s.z - ATAN_Q30[k[4:0]];
        end
        else
        begin
            r.x = s.x + (s.y >>> k);
            r.y = s.y - (s.x >>> k);
            r.z = s.z + ATAN_Q30[k[4:0]];
        end
        return r;
    endfunction

    // Q4.30 by Q2.30 product with floor rounding, returned as Q4.30.
    function automatic logic signed [CW-1:0] mul_q30(logic signed [CW-1:0] a,
                                                     logic signed [31:0] b);
        logic signed [CW+31:0] p;
        p = (CW+32)'(a) * (CW+32)'(b);
        return p[CW+29:30];
    endfunction

endpackage

// ----- hw/rtl/box_vertex_affine_transform_core.sv -----
// Takes one box per transfer and returns its eight corners, corner 0 to 7, one per cycle
// while the result side is not stalled. The front end holds while the box at its end still has
// corners to send to the single corner multiply stage, which serves one corner a cycle. A box
// passes a 33-stage front end (angle reduction, 28 CORDIC stages, sine and cosine, three
// matrix stages) and then a three-stage corner path. Coordinates are Q16.16 and saturate;
// the z translation is applied negated.
module box_vertex_affine_transform_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 box_valid,
    output logic                 box_stall,
    input  bvat_pkg::bvat_in_t   box,
    output logic                 corner_valid,
    input  logic                 corner_stall,
    output bvat_pkg::bvat_out_t  corner
);
    import bvat_pkg::*;

    localparam int NF = STEPS + 5;
    localparam int LAST = NF - 1;

    logic [NF-1:0]      fv_reg;
    box_t               pay_reg [NF];
    cord_t              cord_reg [STEPS+1][3];
    logic [2:0]         neg_reg [STEPS+1];
    logic signed [31:0] sin_reg [3];
    logic signed [31:0] cos_reg [3];

    logic signed [CW-1:0] cycz_reg, cysz_reg, sxsy_reg, cxsz_reg, cxcz_reg;
    logic signed [CW-1:0] sxcy_reg, cxsy_reg, sxsz_reg, sxcz_reg, cxcy_reg;
    logic signed [31:0]   sy1_reg, cz1_reg, sz1_reg;

    logic signed [CW-1:0] sxsycz_reg, sxsysz_reg, cxsycz_reg, cxsysz_reg;
    logic signed [CW-1:0] cycz2_reg, cysz2_reg, cxsz2_reg, cxcz2_reg;
    logic signed [CW-1:0] sxcy2_reg, sxsz2_reg, sxcz2_reg, cxcy2_reg;
    logic signed [31:0]   sy2_reg;

    logic signed [MW-1:0] m_reg [3][3];

    logic [2:0] cnt_reg;
    logic       fadv;
    logic       adv;
    logic       emit;

    logic [2:0]         cv_reg;
    logic signed [PW-1:0] prod_reg [3][3];
    logic [2:0]         pneg_reg;
    logic [2:0]         idx1_reg, idx2_reg;
    logic signed [32:0] t1_reg [3];
    logic signed [32:0] t2_reg [3];
    logic signed [RW-1:0] rnd_reg [3];
    bvat_out_t          out_reg;

    logic signed [15:0] ang [3];
    cord_t              init_c [3];
    logic [2:0]         init_neg;
    box_t               pay_in;

    // Corner path moves when its output is empty or being taken.
    assign adv = !cv_reg[2] || !corner_stall;
    assign emit = fv_reg[LAST] && adv;
    assign fadv = !fv_reg[LAST] || (emit && cnt_reg == LAST_CORNER);
    assign box_stall = !fadv;

    assign ang[0] = box.angle_x;
    assign ang[1] = box.angle_y;
    assign ang[2] = box.angle_z;

    always_comb
    begin
        logic signed [35:0] za;
        for (int a = 0; a < 3; a++)
        begin
            za = {{3{ang[a][15]}}, ang[a], 17'b0};
            init_neg[a] = 1'b0;
            if (za > HALF_PI_Q30)
            begin
                za = za - PI_Q30;
                init_neg[a] = 1'b1;
            end
            else if (za < -HALF_PI_Q30)
            begin
                za = za + PI_Q30;
                init_neg[a] = 1'b1;
            end
            init_c[a].x = GAIN_INV;
            init_c[a].y = '0;
            init_c[a].z = za[CW-1:0];
        end
        pay_in.size_x = box.size_x;
        pay_in.size_y = box.size_y;
        pay_in.size_z = box.size_z;
        pay_in.shift_x = box.shift_x;
        pay_in.shift_y = box.shift_y;
        pay_in.shift_nz = -(33'(box.shift_z));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg <= '0;
        end
        else if (fadv)
        begin
            fv_reg <= {fv_reg[NF-2:0], box_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            pay_reg[0] <= pay_in;
            for (int k = 1; k < NF; k++)
            begin
                pay_reg[k] <= pay_reg[k-1];
            end
            for (int a = 0; a < 3; a++)
            begin
                cord_reg[0][a] <= init_c[a];
            end
            neg_reg[0] <= init_neg;
        end
    end

    for (genvar k = 0; k < STEPS; k++)
    begin : g_cordic
        always_ff @(posedge clk)
        begin
            if (fadv)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    cord_reg[k+1][a] <= cordic_step(cord_reg[k][a], k);
                end
                neg_reg[k+1] <= neg_reg[k];
            end
        end
    end

    // Sine and cosine, then the matrix products over three stages.
    always_ff @(posedge clk)
    begin
        if (fadv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                cos_reg[a] <= 32'(neg_reg[STEPS][a] ? -cord_reg[STEPS][a].x
                                                    : cord_reg[STEPS][a].x);
                sin_reg[a] <= 32'(neg_reg[STEPS][a] ? -cord_reg[STEPS][a].y
                                                    : cord_reg[STEPS][a].y);
            end

            cycz_reg <= mul_q30(CW'(cos_reg[1]), cos_reg[2]);
            cysz_reg <= mul_q30(CW'(cos_reg[1]), sin_reg[2]);
            sxsy_reg <= mul_q30(CW'(sin_reg[0]), sin_reg[1]);
            cxsz_reg <= mul_q30(CW'(cos_reg[0]), sin_reg[2]);
            cxcz_reg <= mul_q30(CW'(cos_reg[0]), cos_reg[2]);
            sxcy_reg <= mul_q30(CW'(sin_reg[0]), cos_reg[1]);
            cxsy_reg <= mul_q30(CW'(cos_reg[0]), sin_reg[1]);
            sxsz_reg <= mul_q30(CW'(sin_reg[0]), sin_reg[2]);
            sxcz_reg <= mul_q30(CW'(sin_reg[0]), cos_reg[2]);
            cxcy_reg <= mul_q30(CW'(cos_reg[0]), cos_reg[1]);
            sy1_reg <= sin_reg[1];
            cz1_reg <= cos_reg[2];
            sz1_reg <= sin_reg[2];

            sxsycz_reg <= mul_q30(sxsy_reg, cz1_reg);
            sxsysz_reg <= mul_q30(sxsy_reg, sz1_reg);
            cxsycz_reg <= mul_q30(cxsy_reg, cz1_reg);
            cxsysz_reg <= mul_q30(cxsy_reg, sz1_reg);
            cycz2_reg <= cycz_reg;
            cysz2_reg <= cysz_reg;
            cxsz2_reg <= cxsz_reg;
            cxcz2_reg <= cxcz_reg;
            sxcy2_reg <= sxcy_reg;
            sxsz2_reg <= sxsz_reg;
            sxcz2_reg <= sxcz_reg;
            cxcy2_reg <= cxcy_reg;
            sy2_reg <= sy1_reg;

            m_reg[0][0] <= MW'(cycz2_reg);
            m_reg[0][1] <= -MW'(cysz2_reg);
            m_reg[0][2] <= MW'(sy2_reg);
            m_reg[1][0] <= MW'(sxsycz_reg) + MW'(cxsz2_reg);
            m_reg[1][1] <= MW'(cxcz2_reg) - MW'(sxsysz_reg);
            m_reg[1][2] <= -MW'(sxcy2_reg);
            m_reg[2][0] <= MW'(sxsz2_reg) - MW'(cxsycz_reg);
            m_reg[2][1] <= MW'(cxsysz_reg) + MW'(sxcz2_reg);
            m_reg[2][2] <= MW'(cxcy2_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            cv_reg <= '0;
        end
        else
        begin
            if (emit)
            begin
                cnt_reg <= cnt_reg + 3'd1;
            end
            if (adv)
            begin
                cv_reg <= {cv_reg[1:0], fv_reg[LAST]};
            end
        end
    end

    // Corner path: products, rounded sums, translation with saturation.
    always_ff @(posedge clk)
    begin
        logic signed [31:0] hv [3];
        logic signed [SW-1:0] s;
        logic signed [PW-1:0] pk;
        logic signed [RW:0] fin;
        logic signed [31:0] sat [3];
        if (adv)
        begin
            hv[0] = pay_reg[LAST].size_x;
            hv[1] = pay_reg[LAST].size_y;
            hv[2] = pay_reg[LAST].size_z;
            for (int r = 0; r < 3; r++)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    prod_reg[r][k] <= PW'(m_reg[r][k]) * PW'(hv[k]);
                end
            end
            // A set bit marks a corner coordinate that takes the negated half size.
            pneg_reg <= ~{cnt_reg[2], cnt_reg[1], cnt_reg[1] ^ cnt_reg[0]};
            idx1_reg <= cnt_reg;
            t1_reg[0] <= 33'(pay_reg[LAST].shift_x);
            t1_reg[1] <= 33'(pay_reg[LAST].shift_y);
            t1_reg[2] <= pay_reg[LAST].shift_nz;

            for (int r = 0; r < 3; r++)
            begin
                s = '0;
                for (int k = 0; k < 3; k++)
                begin
                    pk = pneg_reg[k] ? -prod_reg[r][k] : prod_reg[r][k];
                    s = s + SW'(pk);
                end
                s = s + (SW'(1) <<< 30);
                rnd_reg[r] <= s[SW-1:31];
                t2_reg[r] <= t1_reg[r];
            end
            idx2_reg <= idx1_reg;

            for (int r = 0; r < 3; r++)
            begin
                fin = (RW+1)'(rnd_reg[r]) + (RW+1)'(t2_reg[r]);
                if ((&fin[RW:31]) || !(|fin[RW:31]))
                begin
                    sat[r] = fin[31:0];
                end
                else
                begin
                    sat[r] = fin[RW] ? 32'sh80000000 : 32'sh7FFFFFFF;
                end
            end
            out_reg.corner_index <= idx2_reg;
            out_reg.pos_x <= sat[0];
            out_reg.pos_y <= sat[1];
            out_reg.pos_z <= sat[2];
            out_reg.last_corner <= (idx2_reg == LAST_CORNER);
        end
    end

    assign corner_valid = cv_reg[2];
    assign corner = out_reg;

endmodule

// ----- hw/rtl/bvat_checker.sv -----
module bvat_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 box_valid,
    input logic                 box_stall,
    input bvat_pkg::bvat_in_t   box,
    input logic                 corner_valid,
    input logic                 corner_stall,
    input bvat_pkg::bvat_out_t  corner
);
    import bvat_pkg::*;

    // A stalled corner holds.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid && corner_stall |=> corner_valid && $stable(corner))
        else $error("stalled corner changed");

    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid |-> (corner.last_corner == (corner.corner_index == LAST_CORNER)))
        else $error("last_corner does not match corner_index");

    // The corners of one box leave back to back once the first is taken.
    a_next: assert property (@(posedge clk) disable iff (!rst_n)
        corner_valid && !corner_stall && corner.corner_index != LAST_CORNER |=>
        corner_valid && corner.corner_index == $past(corner.corner_index) + 3'd1)
        else $error("corner sequence broken");

    a_reset: assert property (@(posedge clk) !rst_n |=> !corner_valid)
        else $error("corner valid after reset");

endmodule

bind box_vertex_affine_transform_core bvat_checker u_bvat_checker (.*);
